@@ sv/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Item and result structs, action and status codes, default sizes.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned NAME_BYTES_DEF = 20;
	localparam int unsigned NAME_MAX_W     = 160;

	typedef logic [2:0] action_t;
	typedef logic [1:0] status_t;

	localparam action_t ACT_PUSH_FRONT = 3'd0;
	localparam action_t ACT_PUSH_REAR  = 3'd1;
	localparam action_t ACT_POP_FRONT  = 3'd2;
	localparam action_t ACT_POP_REAR   = 3'd3;
	localparam action_t ACT_PEEK_FRONT = 3'd4;
	localparam action_t ACT_PEEK_REAR  = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] number;
		logic [63:0]        name_bytes_0_7;
		logic [63:0]        name_bytes_8_15;
		logic [31:0]        name_bytes_16_19;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] entry_number;
		logic [63:0]        entry_name_0_7;
		logic [63:0]        entry_name_8_15;
		logic [31:0]        entry_name_16_19;
		logic [4:0]         fill_count;
	} result_t;

	// per-item control from the pointer logic
	typedef struct packed {
		logic    wr;
		logic    rd;
		status_t status;
	} op_t;

endpackage

@@ sv/deq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, registered-read RAM
// One write and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/deq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl: ring pointers and entry count
// Decodes one action, picks the slot, updates head, tail and count.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  action_t       action,
	output op_t           op,
	output logic [AW-1:0] waddr,
	output logic [AW-1:0] raddr,
	output logic [CW-1:0] count
);

	logic [AW-1:0] head_q, tail_q, head_n, tail_n;
	logic [CW-1:0] count_q, count_n;
	logic          full, empty;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		op.wr     = 1'b0;
		op.rd     = 1'b0;
		op.status = ST_OK;
		waddr     = tail_q;
		raddr     = head_q;
		head_n    = head_q;
		tail_n    = tail_q;
		count_n   = count_q;
		unique case (action)
			ACT_PUSH_FRONT: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr   = 1'b1;
					head_n  = prev_slot(head_q);
					waddr   = head_n;
					count_n = count_q + 1'b1;
				end
			end
			ACT_PUSH_REAR: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr   = 1'b1;
					waddr   = tail_q;
					tail_n  = next_slot(tail_q);
					count_n = count_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd   = 1'b1;
					raddr   = head_q;
					head_n  = next_slot(head_q);
					count_n = count_q - 1'b1;
				end
			end
			ACT_POP_REAR: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd   = 1'b1;
					tail_n  = prev_slot(tail_q);
					raddr   = tail_n;
					count_n = count_q - 1'b1;
				end
			end
			ACT_PEEK_FRONT: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd = 1'b1;
					raddr = head_q;
				end
			end
			ACT_PEEK_REAR: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd = 1'b1;
					raddr = prev_slot(tail_q);
				end
			end
			default: begin
				op.status = ST_OK;
			end
		endcase
	end

	assign count = count_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (valid) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

endmodule

@@ sv/double_ended_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a ring of DEPTH entries
// Push and pop at either end, peek at either end, one action per item.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+---------
// item     | start, busy          | cmd
// result   | done (one cycle)     | result
//
// One item per cycle; busy is never raised.
// The result passes the input register, then the entry RAM read register
// alongside the status and count registers.
// Reset clears pointers, count and strobes; entry RAM is not cleared.
// The receiver cannot stall; every result is shown for one cycle only.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned NAME_BYTES = NAME_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW     = $clog2(DEPTH + 1);
	localparam int unsigned NAME_W = 8 * NAME_BYTES;
	localparam int unsigned ENT_W  = 32 + NAME_W;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	op_t                    op;
	logic [AW-1:0]          waddr, raddr;
	logic [CW-1:0]          count;
	logic [NAME_MAX_W-1:0]  name_in, name_out;
	logic [ENT_W-1:0]       wdata, rdata;
	logic                   done_s2, rd_s2;
	status_t                status_s2;
	logic [4:0]             fill_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.action (cmd_s1.action),
		.op     (op),
		.waddr  (waddr),
		.raddr  (raddr),
		.count  (count)
	);

	assign name_in = {cmd_s1.name_bytes_16_19, cmd_s1.name_bytes_8_15,
		cmd_s1.name_bytes_0_7};
	assign wdata   = {cmd_s1.number, name_in[NAME_W-1:0]};

	deq_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (valid_s1 && op.wr),
		.waddr (waddr),
		.wdata (wdata),
		.re    (valid_s1 && op.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rd_s2     <= op.rd;
			status_s2 <= op.status;
			fill_s2   <= 5'(count);
		end
	end

	assign name_out = NAME_MAX_W'(rdata[NAME_W-1:0]);

	assign done = done_s2;

	always_comb begin
		result.status           = status_s2;
		result.fill_count       = fill_s2;
		result.entry_number     = '0;
		result.entry_name_0_7   = '0;
		result.entry_name_8_15  = '0;
		result.entry_name_16_19 = '0;
		if (rd_s2) begin
			result.entry_number     = rdata[ENT_W-1 -: 32];
			result.entry_name_0_7   = name_out[63:0];
			result.entry_name_8_15  = name_out[127:64];
			result.entry_name_16_19 = name_out[159:128];
		end
	end

endmodule

@@ sv/deq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Result timing and status consistency, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input cmd_t    cmd,
	input logic    done,
	input result_t result
);

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		##2 (done |-> $past(start && !busy, 2)))
		else $error("result without an accepted item");

	a_full_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		##2 ((done && result.status == ST_FULL) |->
			(($past(cmd.action, 2) == ACT_PUSH_FRONT ||
			  $past(cmd.action, 2) == ACT_PUSH_REAR) &&
			 result.fill_count == 5'(DEPTH))))
		else $error("full status not from a push at capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |-> (result.fill_count == '0))
		else $error("empty status with entries held");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |->
			(result.entry_number == '0 && result.entry_name_0_7 == '0 &&
			 result.entry_name_8_15 == '0 && result.entry_name_16_19 == '0))
		else $error("refused action returned entry data");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for double_ended_queue
// Drives push, pop and peek items at both ends with random idle cycles,
// models the ring, head, tail and count in the bench, and checks every
// result strobe field by field against the modelled outcome, in order.
// ----------------------------------------------------------------------------
module testbench;
	import deq_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [NAME_MAX_W-1:0] NAME_KEEP = (NAME_BYTES_DEF >= 20) ?
		{NAME_MAX_W{1'b1}} : ((160'd1 << (8 * NAME_BYTES_DEF)) - 160'd1);
	localparam action_t ACT_SPARE_A = 3'd6;
	localparam action_t ACT_SPARE_B = 3'd7;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	cmd_t    pending[$];
	result_t results_due[$];

	// bench copy of the deque
	logic signed [31:0]      ring_number[SLOTS];
	logic [NAME_MAX_W-1:0]   ring_name[SLOTS];
	int                      front_slot = 0;
	int                      rear_slot  = 0;
	int                      held       = 0;

	int      faults       = 0;
	int      items_taken  = 0;
	int      results_seen = 0;
	int      empty_hits   = 0;
	int      full_hits    = 0;
	int      quiet        = 0;
	bit      hold_off;
	result_t next_result;
	result_t due;

	double_ended_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_fault(string what);
		faults++;
		if (faults <= 40)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic cmd_t make_cmd(action_t a, logic signed [31:0] n,
			logic [NAME_MAX_W-1:0] nm);
		cmd_t c;
		c.action           = a;
		c.number           = n;
		c.name_bytes_0_7   = nm[63:0];
		c.name_bytes_8_15  = nm[127:64];
		c.name_bytes_16_19 = nm[159:128];
		return c;
	endfunction

	function automatic cmd_t random_cmd(action_t a);
		logic signed [31:0]    n;
		logic [NAME_MAX_W-1:0] nm;
		n  = $urandom;
		nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 15))
		0: n = 32'sh8000_0000;
		1: n = 32'sh7fff_ffff;
		2: n = -32'sd1;
		3: nm = '0;
		4: nm = {NAME_MAX_W{1'b1}};
		default: ;
		endcase
		return make_cmd(a, n, nm);
	endfunction

	// outcome of one action; updates the bench copy of the deque
	function automatic result_t deque_outcome(cmd_t c);
		result_t r;
		int      slot;
		r        = '0;
		r.status = ST_OK;
		slot     = 0;
		case (c.action)
		ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
			if (held >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				if (c.action == ACT_PUSH_FRONT) begin
					front_slot = (front_slot + SLOTS - 1) % SLOTS;
					slot       = front_slot;
				end else begin
					slot      = rear_slot;
					rear_slot = (rear_slot + 1) % SLOTS;
				end
				ring_number[slot] = c.number;
				ring_name[slot]   = {c.name_bytes_16_19, c.name_bytes_8_15,
					c.name_bytes_0_7} & NAME_KEEP;
				held++;
			end
		end
		ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				case (c.action)
				ACT_POP_FRONT: begin
					slot       = front_slot;
					front_slot = (front_slot + 1) % SLOTS;
					held--;
				end
				ACT_POP_REAR: begin
					rear_slot = (rear_slot + SLOTS - 1) % SLOTS;
					slot      = rear_slot;
					held--;
				end
				ACT_PEEK_FRONT: slot = front_slot;
				default:        slot = (rear_slot + SLOTS - 1) % SLOTS;
				endcase
				r.entry_number = ring_number[slot];
				{r.entry_name_16_19, r.entry_name_8_15, r.entry_name_0_7} =
					ring_name[slot];
			end
		end
		default: ;
		endcase
		r.fill_count = held[4:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				next_result = deque_outcome(cmd);
				results_due.push_back(next_result);
				items_taken++;
				if (next_result.status == ST_EMPTY)
					empty_hits++;
				if (next_result.status == ST_FULL)
					full_hits++;
			end
			if (!(start && busy)) begin
				// no idling through a stretch in the middle of the run
				hold_off = (items_taken < 250 || items_taken >= 420) &&
					($urandom_range(0, 99) < 28);
				if (pending.size() != 0 && !hold_off) begin
					start <= 1'b1;
					cmd   <= pending.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (results_due.size() == 0) begin
				report_fault("result strobe with nothing outstanding");
			end else begin
				due = results_due.pop_front();
				if (result.status !== due.status)
					report_fault($sformatf("status %0d, want %0d",
						result.status, due.status));
				if (result.entry_number !== due.entry_number)
					report_fault($sformatf("entry_number %0d, want %0d",
						result.entry_number, due.entry_number));
				if (result.entry_name_0_7 !== due.entry_name_0_7)
					report_fault($sformatf("entry_name_0_7 %h, want %h",
						result.entry_name_0_7, due.entry_name_0_7));
				if (result.entry_name_8_15 !== due.entry_name_8_15)
					report_fault($sformatf("entry_name_8_15 %h, want %h",
						result.entry_name_8_15, due.entry_name_8_15));
				if (result.entry_name_16_19 !== due.entry_name_16_19)
					report_fault($sformatf("entry_name_16_19 %h, want %h",
						result.entry_name_16_19, due.entry_name_16_19));
				if (result.fill_count !== due.fill_count)
					report_fault($sformatf("fill_count %0d, want %0d",
						result.fill_count, due.fill_count));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int counted;
		int burst;
		int push_pct;
		action_t a;

		// empty queue, ends at their extremes, spare codes
		pending.push_back(random_cmd(ACT_POP_REAR));
		pending.push_back(random_cmd(ACT_PEEK_FRONT));
		pending.push_back(make_cmd(ACT_PUSH_FRONT, 32'sh8000_0000, {NAME_MAX_W{1'b1}}));
		pending.push_back(make_cmd(ACT_PUSH_REAR, 32'sh7fff_ffff, '0));
		pending.push_back(random_cmd(ACT_PEEK_FRONT));
		pending.push_back(random_cmd(ACT_PEEK_REAR));
		pending.push_back(random_cmd(ACT_SPARE_A));
		pending.push_back(random_cmd(ACT_SPARE_B));
		// fill to the brim, then push into a full queue at both ends
		for (int i = 0; i < SLOTS - 2; i++)
			pending.push_back(random_cmd(i % 2 ? ACT_PUSH_REAR : ACT_PUSH_FRONT));
		pending.push_back(random_cmd(ACT_PUSH_FRONT));
		pending.push_back(random_cmd(ACT_PUSH_REAR));
		pending.push_back(random_cmd(ACT_POP_FRONT));
		pending.push_back(random_cmd(ACT_POP_REAR));

		// bursts that lean towards filling, draining or neither
		counted = 0;
		while (counted < 600) begin
			case ($urandom_range(0, 2))
			0:       push_pct = 85;
			1:       push_pct = 15;
			default: push_pct = 50;
			endcase
			burst = $urandom_range(4, 30);
			repeat (burst) begin
				if ($urandom_range(0, 99) < 4) begin
					pending.push_back(random_cmd($urandom_range(0, 1) ?
						ACT_SPARE_A : ACT_SPARE_B));
				end else begin
					if ($urandom_range(0, 99) < push_pct)
						a = action_t'(ACT_PUSH_FRONT + $urandom_range(0, 1));
					else
						a = action_t'(ACT_POP_FRONT + $urandom_range(0, 3));
					pending.push_back(random_cmd(a));
					counted++;
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || start || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run took %0d items and checked %0d results.", items_taken,
			results_seen);
		$display("%0d pushes met a full queue, %0d reads met an empty one.",
			full_hits, empty_hits);
		if (faults == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", faults);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
